// ===== rtl/core/pdtd_pkg.sv =====
// Shared types and constants for the PWM duty temperature decoder.
// Holds the sequencer state type, the command and status structs and
// the fixed-point temperature constants. No dependencies.
package pdtd_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_DUTY,
    ST_DIV_DUTY,
    ST_RING_UPD,
    ST_LOAD_AVG,
    ST_MUL_SQ,
    ST_MUL_SCALE,
    ST_FINISH
  } pdtd_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic fall_take;     // record a falling edge time
    logic rise_take;     // record a rising edge, capture period and on time
    logic div_load_duty; // load divider with on / period
    logic div_load_avg;  // form sum / window by reciprocal multiply
    logic div_step;      // one restoring division step
    logic ram_rd;        // read ring entry at current position
    logic ring_upd;      // replace ring entry, update running sum
    logic mul_sq;        // capture average, square and linear product
    logic mul_scale;     // scale square by quadratic coefficient
    logic out_load;      // load result registers
  } pdtd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic period_zero;   // incoming rising edge gives a zero period
    logic div_busy;      // divider still has steps to do
  } pdtd_sts_t;

  // Width of the timer, the duty ratio and the temperature
  localparam int TS_W   = 32;
  localparam int DUTY_W = 16;
  localparam int TEMP_W = 15;

  // Quadratic formula, scaled by 2^32:
  //   -143*a^2 + 21456*a*2^16 - 6860*2^32, rounded by adding 2^31
  localparam logic [7:0]         QUAD_A   = 8'd143;
  localparam logic [DUTY_W-1:0]  QUAD_B   = 16'd21456;
  localparam logic signed [49:0] QUAD_C   = 50'sd6860 <<< 32;
  localparam logic signed [49:0] QUAD_RND = 50'sd1 <<< 31;

  // Linear formula, scaled by 2^17: 42554*a - 13617*2^16, rounded by 2^16
  localparam logic [DUTY_W-1:0]  LIN_B    = 16'd42554;
  localparam logic signed [33:0] LIN_C    = 34'sd13617 <<< 16;
  localparam logic signed [33:0] LIN_RND  = 34'sd1 <<< 16;

  localparam logic [DUTY_W-1:0]  DUTY_MAX = '1;

endpackage

// ===== rtl/core/pdtd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the duty ring. No dependencies.
module pdtd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/pdtd_ctrl.sv =====
// Sequencer for the PWM duty temperature decoder.
// Steps the datapath through division, ring update and temperature math.
// Depends on pdtd_pkg.
module pdtd_ctrl
  import pdtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_edge_rising,
  output logic      out_valid,
  input  logic      out_ready,
  input  pdtd_sts_t sts,
  output pdtd_cmd_t cmd
);

  pdtd_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_edge_rising) begin
            cmd.rise_take = 1'b1;
            if (!sts.period_zero) begin
              state_nxt = ST_LOAD_DUTY;
            end
          end else begin
            cmd.fall_take = 1'b1;
          end
        end
      end
      ST_LOAD_DUTY: begin
        cmd.div_load_duty = 1'b1;
        cmd.ram_rd        = 1'b1;
        state_nxt         = ST_DIV_DUTY;
      end
      ST_DIV_DUTY: begin
        if (sts.div_busy) begin
          cmd.div_step = 1'b1;
        end else begin
          state_nxt = ST_RING_UPD;
        end
      end
      ST_RING_UPD: begin
        cmd.ring_upd = 1'b1;
        state_nxt    = ST_LOAD_AVG;
      end
      ST_LOAD_AVG: begin
        cmd.div_load_avg = 1'b1;
        state_nxt        = ST_MUL_SQ;
      end
      ST_MUL_SQ: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = ST_MUL_SCALE;
      end
      ST_MUL_SCALE: begin
        cmd.mul_scale = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result slot is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result slot: set on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  // A result is only loaded into a free slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transfer");

  // A new result only appears after the finish step
  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_valid_r) && out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result valid raised outside finish");

  // No division step without pending steps
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> sts.div_busy)
    else $error("division step with no steps left");

endmodule

// ===== rtl/core/pdtd_dpath.sv =====
// Datapath for the PWM duty temperature decoder: edge times, serial
// divider, duty ring with running sum, temperature polynomial, results.
// Depends on pdtd_pkg and pdtd_ram.
module pdtd_dpath
  import pdtd_pkg::*;
#(
  parameter int WINDOW_LEN = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [TS_W-1:0]          in_timestamp,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_quadratic_mode,
  input  pdtd_cmd_t                cmd,
  output pdtd_sts_t                sts,
  output logic [TS_W-1:0]          out_period_ticks,
  output logic [DUTY_W-1:0]        out_duty_raw,
  output logic [DUTY_W-1:0]        out_duty_average,
  output logic signed [TEMP_W-1:0] out_temperature_centi
);

  localparam int SUM_W = $clog2(WINDOW_LEN * 65535 + 1);
  localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W = $clog2(DUTY_W + 1);
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_LEN * 65535);
  // Average by reciprocal: floor(sum * ceil(2^SH / W) / 2^SH) is exact
  // for every sum below 2^SUM_W when SH = SUM_W + ceil(log2(W))
  localparam int AVG_L  = $clog2(WINDOW_LEN);
  localparam int AVG_SH = SUM_W + AVG_L;
  localparam logic [SUM_W:0] AVG_M =
    (SUM_W+1)'(((longint'(1) <<< AVG_SH) + WINDOW_LEN - 1) / WINDOW_LEN);

  // Edge times and per-period values
  logic [TS_W-1:0]   rise_r, fall_r, period_r, on_r;
  logic              quad_r;
  // Serial divider
  logic [TS_W-1:0]   rem_r, divisor_r;
  logic [SUM_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              sat_r;
  logic [TS_W:0]     rem_shift;
  logic              q_bit;
  logic [2*SUM_W:0]  avg_prod;
  // Ring
  logic [PTR_W-1:0]  pos_r;
  logic              full_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DUTY_W-1:0] old_duty, duty_val, duty_r;
  logic [DUTY_W-1:0] ram_rd_data;
  // Temperature
  logic [DUTY_W-1:0] avg_r;
  logic [31:0]       sq_r, lin_r;
  logic [39:0]       scaled_r;
  logic [DUTY_W-1:0] coef;
  logic signed [49:0] quad_x;
  logic signed [33:0] lin_x;
  logic [TEMP_W-1:0]  temp_val;
  // Results
  logic [TS_W-1:0]          res_period_r;
  logic [DUTY_W-1:0]        res_duty_r, res_avg_r;
  logic signed [TEMP_W-1:0] res_temp_r;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r <= 1'b1;
    end else if (cfg_valid) begin
      quad_r <= cfg_quadratic_mode;
    end
  end

  // Edge times; period and on time use the previous rise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r <= '0;
      fall_r <= '0;
    end else begin
      if (cmd.fall_take) begin
        fall_r <= in_timestamp;
      end
      if (cmd.rise_take) begin
        rise_r <= in_timestamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rise_take) begin
      period_r <= in_timestamp - rise_r;
      on_r     <= fall_r - rise_r;
    end
  end

  assign sts.period_zero = (in_timestamp == rise_r);
  assign sts.div_busy    = (cnt_r != '0);

  // Restoring division, one quotient bit per step
  assign rem_shift = {rem_r, dvd_r[SUM_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor_r});
  assign avg_prod  = sum_r * AVG_M;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_load_duty) begin
      cnt_r <= CNT_W'(DUTY_W);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load_duty) begin
      // on >= period saturates; start from zero then so the remainder stays small
      sat_r     <= (on_r >= period_r);
      rem_r     <= (on_r >= period_r) ? '0 : on_r;
      dvd_r     <= '0;
      divisor_r <= period_r;
    end else if (cmd.div_load_avg) begin
      dvd_r <= SUM_W'(avg_prod >> AVG_SH);
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? TS_W'(rem_shift - {1'b0, divisor_r}) : rem_shift[TS_W-1:0];
      dvd_r <= {dvd_r[SUM_W-2:0], q_bit};
    end
  end

  // Duty ring storage
  pdtd_ram #(
    .WIDTH (DUTY_W),
    .DEPTH (WINDOW_LEN),
    .AW    (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.ring_upd),
    .wr_addr (pos_r),
    .wr_data (duty_val),
    .rd_en   (cmd.ram_rd),
    .rd_addr (pos_r),
    .rd_data (ram_rd_data)
  );

  // Entries are written in order, so the slot at pos_r holds data once wrapped
  assign old_duty = full_r ? ram_rd_data : '0;
  assign duty_val = sat_r ? DUTY_MAX : dvd_r[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
    end else if (cmd.ring_upd) begin
      sum_r <= sum_r - SUM_W'(old_duty) + SUM_W'(duty_val);
      if (pos_r == PTR_W'(WINDOW_LEN - 1)) begin
        pos_r  <= '0;
        full_r <= 1'b1;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring_upd) begin
      duty_r <= duty_val;
    end
  end

  // Temperature: square and linear term, then scaled square
  assign coef = quad_r ? QUAD_B : LIN_B;

  always_ff @(posedge clk) begin
    if (cmd.mul_sq) begin
      avg_r <= dvd_r[DUTY_W-1:0];
      sq_r  <= dvd_r[DUTY_W-1:0] * dvd_r[DUTY_W-1:0];
      lin_r <= dvd_r[DUTY_W-1:0] * coef;
    end
    if (cmd.mul_scale) begin
      scaled_r <= sq_r * QUAD_A;
    end
  end

  // Round and drop the scale factor
  assign quad_x = $signed({2'b00, lin_r, 16'h0000}) - $signed({10'd0, scaled_r})
                  - QUAD_C + QUAD_RND;
  assign lin_x  = $signed({2'b00, lin_r}) - LIN_C + LIN_RND;
  assign temp_val = quad_r ? quad_x[46:32] : lin_x[31:17];

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_period_r <= period_r;
      res_duty_r   <= duty_r;
      res_avg_r    <= avg_r;
      res_temp_r   <= $signed(temp_val);
    end
  end

  assign out_period_ticks      = res_period_r;
  assign out_duty_raw          = res_duty_r;
  assign out_duty_average      = res_avg_r;
  assign out_temperature_centi = res_temp_r;

  // Division remainder stays below the divisor while steps remain
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (rem_r < divisor_r))
    else $error("divider remainder out of range");

  // The ring position advances on every ring update
  a_pos_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ring_upd |=> (pos_r == (($past(pos_r) == PTR_W'(WINDOW_LEN - 1)) ? '0
                                : $past(pos_r) + 1'b1)))
    else $error("ring position did not advance");

  // The running sum never exceeds a window of saturated entries
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_MAX)
    else $error("running duty sum out of range");

endmodule

// ===== rtl/core/pwm_duty_temperature_decoder.sv =====
// PWM duty temperature decoder: takes sensor edge events (polarity and a
// 32-bit timer capture) and returns period, duty, averaged duty and
// temperature in centidegrees for every rising edge with a nonzero period.
// A falling edge, or a rising edge with a zero period, is taken in idle
// and gives no result. A rising edge with a result occupies the block for
// the transfer, setup, the serial restoring divider that forms the duty
// ratio (16 steps and one to finish), the ring update, averaging by
// reciprocal multiply, the two temperature multiplies and the result load
// before the next edge can be taken. The result is valid from the
// cycle the block returns to idle. A finished result waits in an output
// register while the next edge is taken; the final step holds only while an
// earlier result is still waiting. quadratic_mode resets to 1 and selects
// the quadratic formula.
// Instantiates pdtd_ctrl and pdtd_dpath; depends on pdtd_pkg.
module pwm_duty_temperature_decoder
  import pdtd_pkg::*;
#(
  parameter int WINDOW_LEN = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_edge_rising,
  input  logic [TS_W-1:0]          in_timestamp,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [TS_W-1:0]          out_period_ticks,
  output logic [DUTY_W-1:0]        out_duty_raw,
  output logic [DUTY_W-1:0]        out_duty_average,
  output logic signed [TEMP_W-1:0] out_temperature_centi,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_quadratic_mode
);

  pdtd_cmd_t cmd;
  pdtd_sts_t sts;

  pdtd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_edge_rising (in_edge_rising),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  pdtd_dpath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_timestamp          (in_timestamp),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_quadratic_mode    (cfg_quadratic_mode),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_period_ticks      (out_period_ticks),
    .out_duty_raw          (out_duty_raw),
    .out_duty_average      (out_duty_average),
    .out_temperature_centi (out_temperature_centi)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for pwm_duty_temperature_decoder: drives sensor edge
// transfers, predicts period, duty, average and temperature, and checks every
// result transfer. Depends on pdtd_pkg and the decoder RTL only.
module tb
  import pdtd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 60;   // settle time before a mode write, well over one decode
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int PHASE_ITEMS   = 190;
  localparam int MAX_REPORTS   = 100;

  typedef struct {
    logic            rising;
    logic [TS_W-1:0] stamp;
  } edge_item_t;

  typedef struct {
    logic [TS_W-1:0]          period;
    logic [DUTY_W-1:0]        duty;
    logic [DUTY_W-1:0]        avg;
    logic signed [TEMP_W-1:0] temp;
  } reading_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_edge_rising = 1'b0;
  logic [TS_W-1:0]          in_timestamp = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [TS_W-1:0]          out_period_ticks;
  logic [DUTY_W-1:0]        out_duty_raw;
  logic [DUTY_W-1:0]        out_duty_average;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_quadratic_mode = 1'b0;

  edge_item_t pending_edges[$];
  reading_t   readings_due[$];
  int         sent_count = 0;
  int         accepted_count = 0;
  int         mismatches = 0;
  int         sender_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       long_hold_armed = 1'b0;
  int         hold_count = 0;
  logic [TS_W-1:0] edge_cursor = '0;

  // Predictor state
  logic [TS_W-1:0]   prior_rise = '0;
  logic [TS_W-1:0]   last_rise = '0;
  logic [TS_W-1:0]   last_fall = '0;
  logic [DUTY_W-1:0] duty_hist [8];
  logic [2:0]        hist_pos = '0;
  logic [18:0]       duty_total = '0;
  logic              quad_sel = 1'b1;

  pwm_duty_temperature_decoder #(
    .WINDOW_LEN(8)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_edge_rising       (in_edge_rising),
    .in_timestamp         (in_timestamp),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_period_ticks     (out_period_ticks),
    .out_duty_raw         (out_duty_raw),
    .out_duty_average     (out_duty_average),
    .out_temperature_centi(out_temperature_centi),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_quadratic_mode   (cfg_quadratic_mode)
  );

  always #5 clk = ~clk;

  // Advance the decoder state for one edge and queue the reading it yields
  task automatic decode_edge(input logic rising, input logic [TS_W-1:0] stamp);
    logic [TS_W-1:0]   period;
    logic [TS_W-1:0]   on_time;
    logic [47:0]       ratio;
    logic [DUTY_W-1:0] duty;
    longint            a;
    longint            x;
    longint            t;
    reading_t          r;
    if (!rising) begin
      last_fall = stamp;
      return;
    end
    prior_rise = last_rise;
    last_rise  = stamp;
    period     = last_rise - prior_rise;
    if (period == '0) return;
    on_time = last_fall - prior_rise;
    ratio   = {on_time, 16'h0000} / {16'h0000, period};
    duty    = (ratio > 48'h00FFFF) ? DUTY_MAX : ratio[DUTY_W-1:0];
    duty_total         = duty_total - duty_hist[hist_pos] + duty;
    duty_hist[hist_pos] = duty;
    hist_pos           = hist_pos + 3'd1;
    a = longint'(duty_total[18:3]);
    if (quad_sel) begin
      // centidegrees scaled by 2^32, round half up
      x = -143 * a * a + 21456 * a * 65536 - (longint'(6860) <<< 32);
      t = (x + (longint'(1) <<< 31)) >>> 32;
    end else begin
      // centidegrees scaled by 2^17, round half up
      x = 42554 * a - (longint'(13617) <<< 16);
      t = (x + 65536) >>> 17;
    end
    r.period = period;
    r.duty   = duty;
    r.avg    = duty_total[18:3];
    r.temp   = t[TEMP_W-1:0];
    readings_due.push_back(r);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Check result transfers, then predict on accepted input transfers
  always @(posedge clk) begin
    reading_t r;
    if (rst_n && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got period %0d", $time,
                   out_period_ticks);
      end else begin
        r = readings_due.pop_front();
        check_field("period_ticks", longint'(r.period), longint'(out_period_ticks));
        check_field("duty_raw", longint'(r.duty), longint'(out_duty_raw));
        check_field("duty_average", longint'(r.avg), longint'(out_duty_average));
        check_field("temperature_centi", longint'(r.temp),
                    longint'(out_temperature_centi));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      decode_edge(in_edge_rising, in_timestamp);
      accepted_count++;
    end
  end

  // Drive the next edge once the current one has transferred
  always @(negedge clk) begin
    edge_item_t e;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (sent_count == accepted_count) begin
      if (pending_edges.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        e = pending_edges.pop_front();
        in_valid       <= 1'b1;
        in_edge_rising <= e.rising;
        in_timestamp   <= e.stamp;
        sent_count++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off when armed, otherwise random stalls
  always @(negedge clk) begin
    if (long_hold_armed && hold_count < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_count++;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_edge(input logic rising, input logic [TS_W-1:0] stamp);
    edge_item_t e;
    e.rising = rising;
    e.stamp  = stamp;
    pending_edges.push_back(e);
  endtask

  // Mostly well-formed PWM periods with random content, plus broken edges and noise
  task automatic queue_pwm_edges(input int n);
    int              queued;
    int              pick;
    logic [TS_W-1:0] period_len;
    logic [TS_W-1:0] on_len;
    logic            at_full;
    queued = 0;
    while (queued < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(2))
          0: period_len = $urandom_range(2000, 1);
          1: period_len = $urandom_range(32'h00FF_FFFF, 2001);
          default: begin
            period_len = $urandom;
            if (period_len == '0) period_len = 1;
          end
        endcase
        on_len = TS_W'(longint'($urandom) % (longint'(period_len) + 1));
        push_edge(1'b0, edge_cursor + on_len);
        push_edge(1'b1, edge_cursor + period_len);
        edge_cursor += period_len;
        queued += 2;
      end else if (pick < 80) begin
        // steady run at an extreme duty fills the whole window
        at_full    = $urandom_range(1);
        period_len = $urandom_range(5000, 10);
        repeat (9) begin
          push_edge(1'b0, edge_cursor + (at_full ? period_len : '0));
          push_edge(1'b1, edge_cursor + period_len);
          edge_cursor += period_len;
        end
        queued += 18;
      end else if (pick < 88) begin
        // repeated rise: zero period
        push_edge(1'b1, edge_cursor);
        queued += 1;
      end else if (pick < 94) begin
        // fall ahead of the previous rise: on time wraps
        period_len = $urandom_range(100000, 1);
        push_edge(1'b0, edge_cursor - $urandom_range(1000, 1));
        push_edge(1'b1, edge_cursor + period_len);
        edge_cursor += period_len;
        queued += 2;
      end else begin
        at_full = $urandom_range(1);
        on_len  = $urandom;
        push_edge(at_full, on_len);
        if (at_full) edge_cursor = on_len;
        queued += 1;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_edges.size() != 0 || sent_count != accepted_count ||
           readings_due.size() != 0)
      @(posedge clk);
  endtask

  // Write the formula select while the decoder is idle
  task automatic write_mode(input logic quad);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_quadratic_mode <= quad;
    do @(posedge clk); while (!cfg_ready);
    quad_sel = quad;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic quad, input int send_pct, input int recv_pct,
                           input logic hold);
    write_mode(quad);
    sender_idle_pct = send_pct;
    recv_stall_pct  = recv_pct;
    queue_pwm_edges(PHASE_ITEMS);
    if (hold) long_hold_armed = 1'b1;
  endtask

  // Stimulus
  initial begin
    foreach (duty_hist[i]) duty_hist[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed edges, quadratic formula from reset
    push_edge(1'b1, 32'd0);              // zero period against the reset rise time
    push_edge(1'b0, 32'd250);
    push_edge(1'b1, 32'd1000);           // quarter duty
    push_edge(1'b1, 32'd1000);           // zero period, ring untouched
    push_edge(1'b0, 32'd1500);
    push_edge(1'b1, 32'd2000);           // half duty
    push_edge(1'b0, 32'd2000);
    push_edge(1'b1, 32'd3000);           // zero on time
    push_edge(1'b0, 32'd4000);
    push_edge(1'b1, 32'd4000);           // full on time, saturates
    push_edge(1'b0, 32'd3000);
    push_edge(1'b1, 32'd5000);           // fall before previous rise
    push_edge(1'b1, 32'hFFFF_FE00);
    push_edge(1'b0, 32'h0000_0010);
    push_edge(1'b1, 32'h0000_0200);      // timer wraps inside the period
    push_edge(1'b1, 32'h0000_01FF);      // largest period
    push_edge(1'b0, 32'hFFFF_FFFF);
    push_edge(1'b1, 32'h0000_0000);      // timer wraps, period 2^32 - 511
    push_edge(1'b0, 32'h0000_0000);
    push_edge(1'b1, 32'h0000_0001);      // period of one, on time zero
    push_edge(1'b0, 32'hAAAA_AAAA);
    push_edge(1'b1, 32'h5555_5555);

    run_phase(1'b0, 0, 0, 1'b0);
    run_phase(1'b1, 68, 0, 1'b0);
    run_phase(1'b0, 0, 68, 1'b0);
    run_phase(1'b1, 26, 26, 1'b0);
    run_phase(1'b0, 0, 0, 1'b1);         // receiver holds off, input backs up

    wait_drained();
    repeat (100) @(posedge clk);
    if (readings_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Timeout: fail the run if it does not finish
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
